/* rtl/range_histogram_density_unit_macros.svh */
// Assertion macros for the range histogram density unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RANGE_HISTOGRAM_DENSITY_UNIT_MACROS_SVH
`define RANGE_HISTOGRAM_DENSITY_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define RHD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RHD_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define RHD_ASSERT_IMP(lbl, pre, post, msg)

`define RHD_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

/* rtl/rhd_pkg.sv */
package rhd_pkg;

  // Default sizes.
  localparam int unsigned MAX_BINS_DEF    = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned MIN_BINS        = 4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_UNIT = 2'd3;

  // Register reset values.
  localparam logic [31:0] RESET_RANGE_START   = 32'd0;
  localparam logic [31:0] RESET_RANGE_END     = 32'd327680;
  localparam logic [6:0]  RESET_BIN_COUNT     = 7'd64;
  localparam logic [31:0] RESET_BINS_PER_UNIT = 32'd838861;

  // Input beat kind carried in tuser.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_RANGE   = 2'd1,
    STAT_EMPTY_RANGE = 2'd2,
    STAT_NO_SAMPLES  = 2'd3
  } status_e;

  // Clamp a counter value to the 32-bit result field.
  function automatic logic [31:0] sat32(input logic [63:0] c);
    logic [31:0] r;
    r = (c > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
    return r;
  endfunction

endpackage

/* rtl/range_histogram_density_unit.sv */
// Streaming histogram with a probability density readout. A sample beat (tuser 0) that is
// binned passes from accept to the next accept through classify, one 32x32 index multiply,
// index clamp, and a read-modify-write of the bin memory; an ignored, invalid or discarded
// sample is only classified. A finish beat (tuser 1) is first checked; then each bin in use
// gets a read, 32 multiply steps and 32 divide steps on the one shared adder/subtractor,
// and a hold of its result beat until it is taken; after the last result the bin memory is
// swept to zero. The same clearing pass runs after reset, while no input beat is taken;
// configuration writes are taken at any time.
`include "range_histogram_density_unit_macros.svh"

module range_histogram_density_unit #(
  parameter int unsigned MAX_BINS    = rhd_pkg::MAX_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = rhd_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: sample_value[31:0], is_finite, bad_reference, zero fill.
  input  logic [39:0]  s_axis_tdata,
  // Fields from bit 0: action.
  input  logic         s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: bin_number[5:0], density[31:0], included_total[31:0],
  // discarded_total[31:0], invalid_total[31:0], status[1:0].
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NBW = $clog2(MAX_BINS + 1);
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned SW  = CW + 2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASS,
    ST_MUL,
    ST_IDX,
    ST_RD,
    ST_WR,
    ST_FCHK,
    ST_FRD,
    ST_FMUL,
    ST_FDIV,
    ST_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [CW:0]       hi_q, hi_d;
  logic [31:0]       lo_q, lo_d;
  logic [63:0]       prod_q, prod_d;
  logic [31:0]       diff_q, diff_d;
  logic [31:0]       smp_q, smp_d;
  logic              fin_q, fin_d;
  logic              bad_q, bad_d;
  logic [CW-1:0]     incl_q, incl_d;
  logic [CW-1:0]     disc_q, disc_d;
  logic [CW-1:0]     inv_q, inv_d;
  logic [5:0]        out_bin_q, out_bin_d;
  logic [31:0]       out_dens_q, out_dens_d;
  rhd_pkg::status_e  out_stat_q, out_stat_d;
  logic              out_last_q, out_last_d;
  logic [31:0]       start_q, start_d;
  logic [31:0]       end_q, end_d;
  logic [6:0]        nbin_q, nbin_d;
  logic [31:0]       bpu_q, bpu_d;

  // Bin memory and its registered read port.
  logic [CW-1:0]     mem [MAX_BINS];
  logic [CW-1:0]     rd_data_q;
  logic              mem_we;
  logic              mem_re;
  logic [CW-1:0]     mem_wdata;

  // Bins in use, clamped to the supported span.
  logic [31:0]       bc32;
  logic [31:0]       nb32;
  logic [NBW-1:0]    nb;
  logic [AW-1:0]     nb_last;

  // Shared adder/subtractor.
  logic [SW-1:0]     sh_a, sh_b, sh_sum;
  logic              sh_sub;
  logic [CW:0]       r2;
  logic              borrow;

  logic [32:0]       diff_full;
  logic [31:0]       idx;

  always_comb begin
    bc32 = {25'd0, nbin_q};
    if (bc32 < 32'(rhd_pkg::MIN_BINS)) begin
      nb32 = 32'(rhd_pkg::MIN_BINS);
    end else if (bc32 > 32'(MAX_BINS)) begin
      nb32 = 32'(MAX_BINS);
    end else begin
      nb32 = bc32;
    end
    nb      = NBW'(nb32);
    nb_last = AW'(nb32 - 32'd1);
  end

  // Operand selection for the shared unit: add for multiply steps, subtract for divide steps.
  always_comb begin
    r2     = {hi_q[CW-1:0], lo_q[31]};
    sh_sub = (state_q == ST_FDIV);
    if (state_q == ST_FDIV) begin
      sh_a = {1'b0, r2};
      sh_b = {2'b00, incl_q};
    end else begin
      sh_a = {1'b0, hi_q};
      sh_b = lo_q[0] ? {2'b00, rd_data_q} : '0;
    end
    sh_sum = sh_a + (sh_sub ? ~sh_b : sh_b) + SW'(sh_sub);
    borrow = sh_sum[SW-1];
  end

  assign diff_full = {smp_q[31], smp_q} - {start_q[31], start_q};
  assign idx       = prod_q[63:32];

  // Memory control.
  assign mem_we    = (state_q == ST_WR) || (state_q == ST_CLEAR);
  assign mem_re    = (state_q == ST_RD) || (state_q == ST_FRD);
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 :
                     ((&rd_data_q) ? rd_data_q : rd_data_q + CW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[addr_q];
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    prod_d     = prod_q;
    diff_d     = diff_q;
    smp_d      = smp_q;
    fin_d      = fin_q;
    bad_d      = bad_q;
    incl_d     = incl_q;
    disc_d     = disc_q;
    inv_d      = inv_q;
    out_bin_d  = out_bin_q;
    out_dens_d = out_dens_q;
    out_stat_d = out_stat_q;
    out_last_d = out_last_q;
    start_d    = start_q;
    end_d      = end_q;
    nbin_d     = nbin_q;
    bpu_d      = bpu_q;

    // Configuration writes.
    if (cfg_we_i) begin
      case (cfg_index_i)
        rhd_pkg::REG_RANGE_START:   start_d = cfg_data_i;
        rhd_pkg::REG_RANGE_END:     end_d   = cfg_data_i;
        rhd_pkg::REG_BIN_COUNT:     nbin_d  = cfg_data_i[6:0];
        rhd_pkg::REG_BINS_PER_UNIT: bpu_d   = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      // Sweep the bin memory to zero.
      ST_CLEAR: begin
        if (addr_q == AW'(MAX_BINS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          smp_d = s_axis_tdata[31:0];
          fin_d = s_axis_tdata[32];
          bad_d = s_axis_tdata[33];
          state_d = (s_axis_tuser == rhd_pkg::ACT_FINISH) ? ST_FCHK : ST_CLASS;
        end
      end

      // Classify the sample against the limits.
      ST_CLASS: begin
        state_d = ST_IDLE;
        if (bad_q) begin
          inv_d = (&inv_q) ? inv_q : inv_q + CW'(1);
        end else if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (($signed(smp_q) < $signed(start_q)) ||
                     ($signed(smp_q) > $signed(end_q))) begin
          disc_d = (&disc_q) ? disc_q : disc_q + CW'(1);
        end else begin
          diff_d  = diff_full[31:0];
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = {32'd0, diff_q} * {32'd0, bpu_q};
        state_d = ST_IDX;
      end

      // Clamp the bin index to the top bin in use.
      ST_IDX: begin
        if (idx >= 32'(nb)) begin
          addr_d = nb_last;
        end else begin
          addr_d = idx[AW-1:0];
        end
        state_d = ST_RD;
      end

      ST_RD: begin
        state_d = ST_WR;
      end

      ST_WR: begin
        incl_d  = (&incl_q) ? incl_q : incl_q + CW'(1);
        state_d = ST_IDLE;
      end

      // Decide between a density readout and a single error result.
      ST_FCHK: begin
        out_bin_d  = '0;
        out_dens_d = '0;
        out_last_d = 1'b1;
        if (!($signed(end_q) > $signed(start_q))) begin
          out_stat_d = rhd_pkg::STAT_BAD_RANGE;
          state_d    = ST_OUT;
        end else if (incl_q == '0) begin
          out_stat_d = (disc_q != '0) ? rhd_pkg::STAT_EMPTY_RANGE : rhd_pkg::STAT_NO_SAMPLES;
          state_d    = ST_OUT;
        end else begin
          out_stat_d = rhd_pkg::STAT_OK;
          addr_d     = '0;
          state_d    = ST_FRD;
        end
      end

      // Read the bin and load the multiplier.
      ST_FRD: begin
        hi_d    = '0;
        lo_d    = bpu_q;
        cnt_d   = '0;
        state_d = ST_FMUL;
      end

      // Shift-add multiply: bins_per_unit times the bin count.
      ST_FMUL: begin
        hi_d  = sh_sum[CW+1:1];
        lo_d  = {sh_sum[0], lo_q[31:1]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = ST_FDIV;
        end
      end

      // Restoring divide by the included count, one quotient bit per step.
      ST_FDIV: begin
        hi_d  = borrow ? r2 : sh_sum[CW:0];
        lo_d  = {lo_q[30:0], ~borrow};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          out_bin_d  = 6'(addr_q);
          out_dens_d = {lo_q[30:0], ~borrow};
          out_last_d = (addr_q == nb_last);
          state_d    = ST_OUT;
        end
      end

      // Hold the result beat until it is taken.
      ST_OUT: begin
        if (m_axis_tready) begin
          if (out_last_q) begin
            incl_d  = '0;
            disc_d  = '0;
            inv_d   = '0;
            addr_d  = '0;
            state_d = ST_CLEAR;
          end else begin
            addr_d  = addr_q + AW'(1);
            state_d = ST_FRD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      addr_q     <= '0;
      cnt_q      <= '0;
      hi_q       <= '0;
      lo_q       <= '0;
      prod_q     <= '0;
      diff_q     <= '0;
      smp_q      <= '0;
      fin_q      <= 1'b0;
      bad_q      <= 1'b0;
      incl_q     <= '0;
      disc_q     <= '0;
      inv_q      <= '0;
      out_bin_q  <= '0;
      out_dens_q <= '0;
      out_stat_q <= rhd_pkg::STAT_OK;
      out_last_q <= 1'b0;
      start_q    <= rhd_pkg::RESET_RANGE_START;
      end_q      <= rhd_pkg::RESET_RANGE_END;
      nbin_q     <= rhd_pkg::RESET_BIN_COUNT;
      bpu_q      <= rhd_pkg::RESET_BINS_PER_UNIT;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      cnt_q      <= cnt_d;
      hi_q       <= hi_d;
      lo_q       <= lo_d;
      prod_q     <= prod_d;
      diff_q     <= diff_d;
      smp_q      <= smp_d;
      fin_q      <= fin_d;
      bad_q      <= bad_d;
      incl_q     <= incl_d;
      disc_q     <= disc_d;
      inv_q      <= inv_d;
      out_bin_q  <= out_bin_d;
      out_dens_q <= out_dens_d;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
      start_q    <= start_d;
      end_q      <= end_d;
      nbin_q     <= nbin_d;
      bpu_q      <= bpu_d;
    end
  end

  // Port drive.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_stat_q,
                          rhd_pkg::sat32(64'(inv_q)),
                          rhd_pkg::sat32(64'(disc_q)),
                          rhd_pkg::sat32(64'(incl_q)),
                          out_dens_q,
                          out_bin_q};

  // Checks on the sequencer.
  `RHD_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid, "input taken during readout")
  `RHD_ASSERT_IMP(a_mid_ok, m_axis_tvalid && !m_axis_tlast, out_stat_q == rhd_pkg::STAT_OK, "error result not marked last")
  `RHD_ASSERT_IMP(a_err_zero, m_axis_tvalid && (out_stat_q != rhd_pkg::STAT_OK), (out_dens_q == '0) && (out_bin_q == '0), "error result carries data")
  `RHD_ASSERT_NXT(a_clear_after, m_axis_tvalid && m_axis_tready && m_axis_tlast, (state_q == ST_CLEAR) && (incl_q == '0) && (disc_q == '0) && (inv_q == '0), "store not cleared after finish")
  `RHD_ASSERT_IMP(a_div_nonzero, state_q == ST_FDIV, incl_q != '0, "divide by zero count")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NUM_BINS         = rhd_pkg::MAX_BINS_DEF;
  // A sample may still be in flight, and the bin sweep runs after a finish.
  localparam int unsigned SETTLE_CYCLES    = 2 * NUM_BINS + 16;
  localparam int unsigned STALL_LIMIT      = 20000;
  localparam int unsigned HOLD_CYCLES      = 1500;
  localparam int unsigned HOLD_AFTER_BEATS = 150;
  localparam int unsigned RANDOM_PER_PHASE = 40;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [5:0]       bin_number;
    logic [31:0]      density;
    logic [31:0]      included_total;
    logic [31:0]      discarded_total;
    logic [31:0]      invalid_total;
    rhd_pkg::status_e status;
    logic             last;
  } density_beat_t;

  // Histogram predictor plus the queue of density beats still to come.
  class density_scoreboard;
    logic [31:0]   lo_limit;
    logic [31:0]   hi_limit;
    logic [6:0]    bin_count;
    logic [31:0]   bins_per_unit;
    logic [31:0]   bin_tally [NUM_BINS];
    logic [31:0]   included;
    logic [31:0]   discarded;
    logic [31:0]   invalid;
    density_beat_t expected_q [$];
    int unsigned   mismatches;
    int unsigned   beats_checked;
    int unsigned   samples_noted;
    int unsigned   finishes_noted;
    int unsigned   status_seen [4];

    function new();
      lo_limit      = rhd_pkg::RESET_RANGE_START;
      hi_limit      = rhd_pkg::RESET_RANGE_END;
      bin_count     = rhd_pkg::RESET_BIN_COUNT;
      bins_per_unit = rhd_pkg::RESET_BINS_PER_UNIT;
      mismatches    = 0;
      beats_checked = 0;
      samples_noted = 0;
      finishes_noted = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_counts();
    endfunction

    static function int unsigned bins_for(logic [6:0] bc);
      if (bc < rhd_pkg::MIN_BINS) return rhd_pkg::MIN_BINS;
      if (bc > NUM_BINS) return NUM_BINS;
      return bc;
    endfunction

    static function logic [31:0] bump(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function void clear_counts();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      included  = '0;
      discarded = '0;
      invalid   = '0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        rhd_pkg::REG_RANGE_START:   lo_limit = data;
        rhd_pkg::REG_RANGE_END:     hi_limit = data;
        rhd_pkg::REG_BIN_COUNT:     bin_count = data[6:0];
        rhd_pkg::REG_BINS_PER_UNIT: bins_per_unit = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted input beat; a finish queues its density beats.
    function void note_beat(logic action, logic [31:0] value, logic finite, logic bad_ref);
      longint signed v;
      longint signed s;
      longint signed e;
      logic [63:0]   diff;
      logic [63:0]   prod;
      int unsigned   nb;
      int unsigned   idx;
      density_beat_t r;
      v  = longint'($signed(value));
      s  = longint'($signed(lo_limit));
      e  = longint'($signed(hi_limit));
      nb = bins_for(bin_count);
      if (action == rhd_pkg::ACT_SAMPLE) begin
        samples_noted++;
        if (bad_ref) begin
          invalid = bump(invalid);
        end else if (finite) begin
          if (v < s || v > e) begin
            discarded = bump(discarded);
          end else begin
            diff = v - s;
            prod = diff * {32'd0, bins_per_unit};
            idx  = (prod[63:32] >= nb) ? nb - 1 : prod[63:32];
            bin_tally[idx] = bump(bin_tally[idx]);
            included = bump(included);
          end
        end
      end else begin
        finishes_noted++;
        r.included_total  = included;
        r.discarded_total = discarded;
        r.invalid_total   = invalid;
        if (!(e > s)) r.status = rhd_pkg::STAT_BAD_RANGE;
        else if (included == 0)
          r.status = (discarded != 0) ? rhd_pkg::STAT_EMPTY_RANGE : rhd_pkg::STAT_NO_SAMPLES;
        else r.status = rhd_pkg::STAT_OK;
        if (r.status != rhd_pkg::STAT_OK) begin
          r.bin_number = '0;
          r.density    = '0;
          r.last       = 1'b1;
          expected_q.push_back(r);
        end else begin
          for (int unsigned b = 0; b < nb; b++) begin
            prod = {32'd0, bins_per_unit} * {32'd0, bin_tally[b]};
            prod = prod / {32'd0, included};
            r.bin_number = 6'(b);
            r.density    = prod[31:0];
            r.last       = (b == nb - 1);
            expected_q.push_back(r);
          end
        end
        clear_counts();
      end
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_beat(density_beat_t got);
      density_beat_t want;
      beats_checked++;
      status_seen[int'(got.status)]++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: bin %0d status %0d last %0d",
                   got.bin_number, got.status, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: bin %0d dens %h incl %0d disc %0d inv %0d st %0d last %0d",
                   want.bin_number, want.density, want.included_total,
                   want.discarded_total, want.invalid_total, want.status, want.last);
          $display("         got: bin %0d dens %h incl %0d disc %0d inv %0d st %0d last %0d",
                   got.bin_number, got.density, got.included_total,
                   got.discarded_total, got.invalid_total, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [1:0]    cfg_index_i;
  logic [31:0]   cfg_data_i;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [39:0]   s_axis_tdata;
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [135:0]  m_axis_tdata;
  logic          m_axis_tlast;

  density_scoreboard sb = new();
  bit                quiet;
  int unsigned       stall_cycles = 0;
  int unsigned       settings_run;

  always #5 clk_i = ~clk_i;

  range_histogram_density_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Mostly short gaps, a few long ones, none in a quiet phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Reciprocal bin width that spreads the range over the bins in use.
  function automatic logic [31:0] bpu_for(logic [31:0] lo, logic [31:0] hi, logic [6:0] bc);
    longint signed w;
    logic [63:0]   q;
    w = longint'($signed(hi)) - longint'($signed(lo));
    if (w <= 0) return $urandom;
    q = (64'(density_scoreboard::bins_for(bc)) << 32) / 64'(w);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] in_range_value();
    longint signed s;
    longint signed e;
    logic [63:0]   off;
    logic [63:0]   sum;
    s = longint'($signed(sb.lo_limit));
    e = longint'($signed(sb.hi_limit));
    if (e < s) return $urandom;
    case ($urandom_range(0, 9))
      0: return sb.lo_limit;
      1: return sb.hi_limit;
      default: begin
        off = {$urandom, $urandom} % 64'(e - s + 1);
        sum = s + off;
        return sum[31:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] out_of_range_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 2))
      0: if (sb.lo_limit != 32'h8000_0000) v = sb.lo_limit - 32'd1;
      1: if (sb.hi_limit != 32'h7FFF_FFFF) v = sb.hi_limit + 32'd1;
      default: ;
    endcase
    return v;
  endfunction

  // Offer one input beat and wait for it to be taken.
  task automatic send_beat(logic action, logic [31:0] value, logic finite, logic bad_ref);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {6'd0, bad_ref, finite, value};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(action, value, finite, bad_ref);
  endtask

  task automatic send_sample(logic [31:0] value, logic finite, logic bad_ref);
    send_beat(rhd_pkg::ACT_SAMPLE, value, finite, bad_ref);
  endtask

  task automatic send_finish();
    send_beat(rhd_pkg::ACT_FINISH, $urandom, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Stop sending until every predicted beat is back and the block is idle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [1:0] index, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(index, data);
  endtask

  task automatic write_config(logic [31:0] lo, logic [31:0] hi, logic [6:0] bc,
                              logic [31:0] bpu);
    put_reg(rhd_pkg::REG_RANGE_START, lo);
    put_reg(rhd_pkg::REG_RANGE_END, hi);
    put_reg(rhd_pkg::REG_BIN_COUNT, {25'd0, bc});
    put_reg(rhd_pkg::REG_BINS_PER_UNIT, bpu);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Edges of the range, each error finish and the flag priorities.
  task automatic run_directed();
    send_finish();
    send_sample(32'd0, 1'b1, 1'b1);
    send_finish();
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_finish();
    send_sample(32'd0, 1'b1, 1'b0);
    send_sample(rhd_pkg::RESET_RANGE_END, 1'b1, 1'b0);
    send_sample(rhd_pkg::RESET_RANGE_END - 32'd1, 1'b1, 1'b0);
    send_sample(32'd5121, 1'b1, 1'b0);
    send_sample(32'd100, 1'b0, 1'b0);
    send_sample(32'd200, 1'b0, 1'b1);
    send_sample(32'd1000, 1'b1, 1'b1);
    send_sample(rhd_pkg::RESET_RANGE_END + 32'd1, 1'b1, 1'b0);
    send_finish();
    // Range end equal to start: still classified, but the finish is an error.
    wait_drained();
    write_config(32'h0001_0000, 32'h0001_0000, 7'd4, 32'd0);
    send_sample(32'h0001_0000, 1'b1, 1'b0);
    send_sample(32'd0, 1'b1, 1'b0);
    send_finish();
  endtask

  // Runs of mostly in-range samples closed by a finish, with some noise.
  task automatic run_phase(logic [31:0] lo, logic [31:0] hi, logic [6:0] bc,
                           logic [31:0] bpu, bit calm);
    int unsigned done;
    int unsigned len;
    int unsigned r;
    logic [31:0] value;
    logic        finite;
    logic        bad_ref;
    wait_drained();
    write_config(lo, hi, bc, bpu);
    quiet = calm;
    done  = 0;
    while (done < RANDOM_PER_PHASE) begin
      len = $urandom_range(0, 20);
      for (int k = 0; k < len; k++) begin
        r       = $urandom_range(0, 99);
        finite  = 1'b1;
        bad_ref = 1'b0;
        if (r < 78) begin
          value = in_range_value();
        end else if (r < 88) begin
          value = out_of_range_value();
        end else if (r < 94) begin
          value  = $urandom;
          finite = 1'b0;
        end else begin
          value   = $urandom;
          finite  = 1'($urandom_range(0, 1));
          bad_ref = 1'b1;
        end
        send_sample(value, finite, bad_ref);
        if (finite || bad_ref) done++;
      end
      send_finish();
      done++;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    quiet = 1'b0;
  endtask

  // Main stimulus sequence.
  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    longint signed top;
    logic [6:0]  bc;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= rhd_pkg::REG_RANGE_START;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= rhd_pkg::ACT_SAMPLE;
    quiet         = 1'b0;
    settings_run  = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    run_phase(32'hFFFE_0000, 32'h0002_0000, 7'd8,
              bpu_for(32'hFFFE_0000, 32'h0002_0000, 7'd8), 1'b0);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 7'd64,
              bpu_for(32'h8000_0000, 32'h7FFF_FFFF, 7'd64), 1'b0);
    run_phase(32'd0, 32'h0000_0100, 7'd4, bpu_for(32'd0, 32'h0000_0100, 7'd4), 1'b1);
    run_phase(32'h0000_1000, 32'h0000_0800, 7'd0, 32'hFFFF_FFFF, 1'b0);
    run_phase(32'hFFFF_FFF6, 32'd90000, 7'd127, 32'd0, 1'b0);
    run_phase(32'h0001_2345, 32'h0005_0000, 7'd16, 32'hFFFF_FFFF, 1'b0);
    run_phase(32'd0, 32'h000A_0000, 7'd5, bpu_for(32'd0, 32'h000A_0000, 7'd5), 1'b0);

    // Random setting, mostly a sensible range.
    lo  = $urandom;
    top = longint'($signed(lo)) + longint'($urandom_range(1, 32'h0010_0000));
    hi  = (top > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : top[31:0];
    bc  = 7'($urandom_range(0, 127));
    run_phase(lo, hi, bc, bpu_for(lo, hi, bc), 1'b0);

    wait_drained();
    $display("Covered %0d samples and %0d finishes over %0d register settings,",
             sb.samples_noted, sb.finishes_noted, settings_run);
    $display("%0d density beats checked (ok %0d, bad range %0d, empty %0d, none %0d).",
             sb.beats_checked, sb.status_seen[0], sb.status_seen[1],
             sb.status_seen[2], sb.status_seen[3]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d beats never seen", sb.mismatches, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random gaps, plus one long hold-off while the sender keeps offering beats.
  initial begin
    int unsigned gap;
    bit          held;
    m_axis_tready <= 1'b0;
    gap  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && rst_ni && m_axis_tvalid && s_axis_tvalid &&
          sb.beats_checked >= HOLD_AFTER_BEATS) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (gap != 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= rst_ni;
        gap = pick_gap();
      end
    end
  end

  // Check every result beat that the block hands over.
  always @(posedge clk_i) begin
    density_beat_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.bin_number      = m_axis_tdata[5:0];
      got.density         = m_axis_tdata[37:6];
      got.included_total  = m_axis_tdata[69:38];
      got.discarded_total = m_axis_tdata[101:70];
      got.invalid_total   = m_axis_tdata[133:102];
      got.status          = rhd_pkg::status_e'(m_axis_tdata[135:134]);
      got.last            = m_axis_tlast;
      sb.check_beat(got);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d beats outstanding",
               stall_cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
